### hdl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and constants of the line command recognizer: command words,
// their lengths and directions, register addresses and the result record.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int CmdCount    = 4;
  localparam int CmdSlots    = 16;
  localparam int PaddrW      = 3;

  localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;
  localparam logic [7:0] MAX_LEN_RESET   = 8'd15;
  localparam logic       REG_MAX_LEN     = 1'b0;

  localparam logic [1:0] DIR_STRAIGHT = 2'd0;
  localparam logic [1:0] DIR_RIGHT    = 2'd1;
  localparam logic [1:0] DIR_LEFT     = 2'd2;

  // command text, padded with zeros to sixteen slots
  localparam logic [7:0] CMD_TEXT [CmdCount][CmdSlots] = '{
    '{"R", "I", "G", "H", "T", "_", "K", "E", "Y", "_", "D", "O", "W", "N",
      8'h00, 8'h00},
    '{"R", "I", "G", "H", "T", "_", "K", "E", "Y", "_", "U", "P", 8'h00, 8'h00,
      8'h00, 8'h00},
    '{"L", "E", "F", "T", "_", "K", "E", "Y", "_", "D", "O", "W", "N", 8'h00,
      8'h00, 8'h00},
    '{"L", "E", "F", "T", "_", "K", "E", "Y", "_", "U", "P", 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00}
  };

  localparam logic [7:0] CMD_LEN [CmdCount] = '{8'd14, 8'd12, 8'd13, 8'd11};
  localparam logic [1:0] CMD_DIR [CmdCount] = '{DIR_RIGHT, DIR_STRAIGHT, DIR_LEFT,
                                                DIR_STRAIGHT};

  typedef struct packed {
    logic       valid;
    logic [1:0] direction;
  } lcr_res_t;

endpackage

### hdl/lcr_cfg.sv
// ----------------------------------------------------------------------------
// lcr_cfg
// Register port holding the maximum line length.
// ----------------------------------------------------------------------------
module lcr_cfg
  import lcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [PaddrW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output logic [7:0]        max_len
);

  logic [7:0] max_len_r;
  logic [7:0] max_len_nxt;
  logic       wr_en;

  // register index is the word address
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_MAX_LEN);

  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en) begin
      max_len_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_LEN) ? {24'd0, max_len_r} : 32'd0;
  assign max_len    = max_len_r;

endmodule

### hdl/lcr_core.sv
// ----------------------------------------------------------------------------
// lcr_core
// Input register and per-byte line matching: position, candidate flags and
// skip flag, giving at most one direction per newline.
// ----------------------------------------------------------------------------
module lcr_core
  import lcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] max_len,
  input  logic       res_ready,
  output lcr_res_t   res
);

  logic                byte_valid_r;
  logic                byte_valid_nxt;
  logic [7:0]          byte_r;
  logic [7:0]          byte_nxt;
  logic [7:0]          pos_r;
  logic [7:0]          pos_nxt;
  logic [CmdCount-1:0] flags_r;
  logic [CmdCount-1:0] flags_nxt;
  logic                skip_r;
  logic                skip_nxt;
  logic                fire;
  logic                accept;
  logic                is_nl;
  logic                found;
  logic [1:0]          found_dir;
  logic [7:0]          pos_inc;

  assign fire     = byte_valid_r && res_ready;
  assign in_stall = byte_valid_r && !res_ready;
  assign accept   = in_valid && !in_stall;
  assign is_nl    = (byte_r == NEWLINE_BYTE);
  assign pos_inc  = (pos_r == 8'd255) ? pos_r : pos_r + 8'd1;

  // first matching command wins
  always_comb begin
    found     = 1'b0;
    found_dir = DIR_STRAIGHT;
    for (int k = CmdCount - 1; k >= 0; k--) begin
      if (flags_r[k] && (pos_r == CMD_LEN[k])) begin
        found     = 1'b1;
        found_dir = CMD_DIR[k];
      end
    end
    if (pos_r >= max_len) begin
      found = 1'b0;
    end
  end

  always_comb begin
    byte_valid_nxt = byte_valid_r;
    byte_nxt       = byte_r;
    pos_nxt        = pos_r;
    flags_nxt      = flags_r;
    skip_nxt       = skip_r;
    res.valid      = 1'b0;
    res.direction  = found_dir;

    if (fire) begin
      byte_valid_nxt = 1'b0;
      if (is_nl) begin
        pos_nxt   = 8'd0;
        flags_nxt = '1;
        skip_nxt  = 1'b0;
        res.valid = !skip_r && found;
      end else if (!skip_r) begin
        for (int k = 0; k < CmdCount; k++) begin
          if (!((pos_r < CMD_LEN[k]) && (CMD_TEXT[k][pos_r[3:0]] == byte_r))) begin
            flags_nxt[k] = 1'b0;
          end
        end
        pos_nxt  = pos_inc;
        skip_nxt = (pos_inc >= max_len);
      end
    end

    if (accept) begin
      byte_valid_nxt = 1'b1;
      byte_nxt       = in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
      pos_r        <= 8'd0;
      flags_r      <= '1;
      skip_r       <= 1'b0;
    end else begin
      byte_valid_r <= byte_valid_nxt;
      pos_r        <= pos_nxt;
      flags_r      <= flags_nxt;
      skip_r       <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

### hdl/lcr_out_fifo.sv
// ----------------------------------------------------------------------------
// lcr_out_fifo
// Two-entry result buffer between the matcher and the output channel.
// ----------------------------------------------------------------------------
module lcr_out_fifo
  import lcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lcr_res_t   res,
  output logic       res_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_direction
);

  logic [1:0] data_r [2];
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic       push;
  logic       pop;

  assign res_ready     = (count_r != 2'd2);
  assign out_valid     = (count_r != 2'd0);
  assign out_direction = data_r[rd_ptr_r];
  assign push          = res.valid;
  assign pop           = out_valid && !out_stall;

  always_comb begin
    count_nxt  = count_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= res.direction;
    end
  end

endmodule

### hdl/line_command_recognizer_top.sv
// ----------------------------------------------------------------------------
// line_command_recognizer_top
// Recognizes newline-terminated key commands in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data_byte carry one text byte per item. A newline
//   that ends the right key-down command gives direction right (1), the left
//   key-down command gives left (2), either key-up command gives straight (0)
//   on the out_ channel. Other lines give nothing. A line reaching
//   max_line_length bytes without a newline is dropped through its newline.
//   max_line_length sits at byte address 0 of the cfg_ port, reset 15;
//   write it only while the block is idle.
// Timing:
//   one byte per cycle sustained while the result buffer has room. out_valid
//   rises once the newline has passed the input register and been written
//   into the result buffer.
//   A two-entry result buffer lets input continue while a result waits; when
//   the receiver stalls and the buffer fills, in_stall rises and holds the
//   byte in the input register.
// Reset:
//   rst_n clears the line state, empties the buffer and restores the limit.
// ----------------------------------------------------------------------------
module line_command_recognizer_top
  import lcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_direction,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [PaddrW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [7:0] max_len;
  logic       res_ready;
  lcr_res_t   res;

  lcr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_len     (max_len)
  );

  lcr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .max_len      (max_len),
    .res_ready    (res_ready),
    .res          (res)
  );

  lcr_out_fifo u_out_fifo (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .res_ready     (res_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_direction (out_direction)
  );

endmodule
